// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// Each one expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PVBP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pvbp assertion failed");

// A waiting transaction keeps valid high and its payload unchanged.
`define PVBP_ASSERT_HOLD(lbl, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
		else $error("pvbp assertion failed");

`endif

// File: rtl/pvbp_pkg.sv
// ----------------------------------------------------------------------------
// pvbp_pkg
// Types and constants shared by the prefix varint bit packer modules.
// ----------------------------------------------------------------------------
package pvbp_pkg;

	// operation codes
	localparam logic [2:0] FUNC_UVAR  = 3'd0;
	localparam logic [2:0] FUNC_SVAR  = 3'd1;
	localparam logic [2:0] FUNC_RAW   = 3'd2;
	localparam logic [2:0] FUNC_LIMIT = 3'd3;
	localparam logic [2:0] FUNC_ALIGN = 3'd4;

	// encoded field: up to 3 prefix bits + 32 raw bits, left aligned
	localparam int ENC_W    = 40;
	localparam int LEN_W    = 6;
	// partial byte on top of the encoded field
	localparam int STREAM_W = ENC_W + 8;

	// varint range limits
	localparam logic [31:0] U1_MAX = 32'h0000_007f;
	localparam logic [31:0] U2_MAX = 32'h0000_3fff;
	localparam logic [31:0] U4_MAX = 32'h1fff_ffff;
	localparam logic [31:0] S1_MAX = 32'h0000_003f;
	localparam logic [31:0] S2_MAX = 32'h0000_1fff;
	localparam logic [31:0] S4_MAX = 32'h0fff_ffff;

	typedef struct packed {
		logic [ENC_W-1:0] bits;   // first bit at the MSB
		logic [LEN_W-1:0] len;    // 0..35
		logic             align;
	} enc_t;

	typedef struct packed {
		logic [ENC_W-1:0] bytes;  // first byte in the top eight bits
		logic [2:0]       nbytes; // 0..5
		logic             bv;
		logic             eom;
	} load_t;

endpackage

// File: rtl/pvbp_field_enc.sv
// ----------------------------------------------------------------------------
// pvbp_field_enc
// Turns one operation into a left-aligned bit string and its length.
// ----------------------------------------------------------------------------
module pvbp_field_enc import pvbp_pkg::*; (
	input  logic [2:0]  func,
	input  logic [31:0] value,
	input  logic [5:0]  nbits,
	input  logic [31:0] limit,
	output enc_t        enc
);

	// bit length by a five-level search
	function automatic logic [5:0] bit_length(input logic [31:0] v);
		logic [31:0] x;
		logic [5:0]  n;
		begin
			x = v;
			n = 6'd0;
			if (x[31:16] != 16'd0) begin
				n = n + 6'd16;
				x = x >> 16;
			end
			if (x[15:8] != 8'd0) begin
				n = n + 6'd8;
				x = x >> 8;
			end
			if (x[7:4] != 4'd0) begin
				n = n + 6'd4;
				x = x >> 4;
			end
			if (x[3:2] != 2'd0) begin
				n = n + 6'd2;
				x = x >> 2;
			end
			if (x[1])
				n = n + 6'd2;
			else if (x[0])
				n = n + 6'd1;
			return n;
		end
	endfunction

	// low byte first, MSB first in each byte; a short tail takes the low bits
	function automatic logic [31:0] raw_left(input logic [31:0] v, input logic [5:0] n);
		logic [31:0] res;
		logic [2:0]  k;
		logic [2:0]  r;
		logic [7:0]  b;
		begin
			res = 32'd0;
			k = n[5:3];
			r = n[2:0];
			for (int j = 0; j < 4; j++) begin
				b = v[8*j +: 8];
				if (3'(j) < k)
					res[31-8*j -: 8] = b;
				else if (3'(j) == k && r != 3'd0)
					res[31-8*j -: 8] = b << (4'd8 - {1'b0, r});
			end
			return res;
		end
	endfunction

	logic        neg;
	logic [31:0] mag;
	logic [5:0]  raw_n;
	logic [5:0]  lim_n;

	assign neg   = value[31];
	assign mag   = neg ? (32'd0 - value) : value;
	assign raw_n = (nbits > 6'd32) ? 6'd32 : nbits;
	assign lim_n = bit_length(limit);

	always_comb begin
		enc = '0;
		unique case (func)
			FUNC_UVAR: begin
				if (value <= U1_MAX) begin
					enc.bits = {1'b1, value[6:0], 32'd0};
					enc.len  = 6'd8;
				end else if (value <= U2_MAX) begin
					enc.bits = {2'b01, value[13:0], 24'd0};
					enc.len  = 6'd16;
				end else if (value <= U4_MAX) begin
					enc.bits = {3'b001, value[28:0], 8'd0};
					enc.len  = 6'd32;
				end else begin
					enc.bits = {3'b000, raw_left(value, 6'd32), 5'd0};
					enc.len  = 6'd35;
				end
			end
			FUNC_SVAR: begin
				if (mag <= S1_MAX) begin
					enc.bits = {1'b1, neg, mag[5:0], 32'd0};
					enc.len  = 6'd8;
				end else if (mag <= S2_MAX) begin
					enc.bits = {2'b01, neg, mag[12:0], 24'd0};
					enc.len  = 6'd16;
				end else if (mag <= S4_MAX) begin
					enc.bits = {3'b001, neg, mag[27:0], 8'd0};
					enc.len  = 6'd32;
				end else begin
					enc.bits = {3'b000, raw_left(value, 6'd32), 5'd0};
					enc.len  = 6'd35;
				end
			end
			FUNC_RAW: begin
				enc.bits = {raw_left(value, raw_n), 8'd0};
				enc.len  = raw_n;
			end
			FUNC_LIMIT: begin
				enc.bits = {raw_left(value, lim_n), 8'd0};
				enc.len  = lim_n;
			end
			FUNC_ALIGN: begin
				enc.align = 1'b1;
			end
			default: begin
				enc = '0;
			end
		endcase
	end

endmodule

// File: rtl/pvbp_byte_queue.sv
// ----------------------------------------------------------------------------
// pvbp_byte_queue
// Holds one item's completed bytes, handing one out per cycle while ready.
// ----------------------------------------------------------------------------
module pvbp_byte_queue import pvbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  load_t      load,
	output logic       free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_message
);

	logic [ENC_W-1:0] bytes_q;
	logic [2:0]       left_q;
	logic             bv_q;
	logic             eom_q;
	logic             pop;

	assign out_valid      = (left_q != 3'd0);
	assign pop            = out_valid && out_ready;
	assign free           = (left_q == 3'd0) || (left_q == 3'd1 && pop);
	assign out_byte       = bytes_q[ENC_W-1 -: 8];
	assign byte_valid     = bv_q;
	assign end_of_message = eom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 3'd0;
		end else if (push) begin
			left_q <= load.nbytes;
		end else if (pop) begin
			left_q <= left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bytes_q <= load.bytes;
			bv_q    <= load.bv;
			eom_q   <= load.eom;
		end else if (pop) begin
			bytes_q <= bytes_q << 8;
		end
	end

endmodule

// File: rtl/prefix_varint_bit_packer_top.sv
// ----------------------------------------------------------------------------
// prefix_varint_bit_packer_top
// Packs varints and bit fields MSB first into a byte stream.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready) takes one operation per transaction:
//   func selects unsigned varint, signed varint, raw field of nbits, field
//   sized by the bit length of limit, or align. Codes 5..7 are dropped.
//   Output channel (out_valid/out_ready) gives one result per transaction:
//   out_byte with byte_valid, and end_of_message on the align result.
//   An accepted transaction is encoded from the input register and pushed
//   into the byte queue when it is free; the queue then offers its bytes.
//   Operations pass at one per cycle while each makes at most one byte
//   and the receiver is ready; one that makes more bytes waits in the
//   input register while the single-byte output port drains the queue.
//   The partial byte (up to 7 bits) carries over between operations and
//   is updated as the operation leaves the input register.
//   Reset clears the partial byte, its bit count and both valid flags.
//   A stalled receiver holds the current byte; the input register still
//   takes one more transaction, and operations that make no byte go on
//   passing through while the queue is full.
// ----------------------------------------------------------------------------
module prefix_varint_bit_packer_top import pvbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] value,
	input  logic [5:0]  nbits,
	input  logic [31:0] limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        end_of_message
);

	// input register
	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [31:0] value_s1;
	logic [5:0]  nbits_s1;
	logic [31:0] limit_s1;

	// carried bit state
	logic [7:0]  partial_q;
	logic [2:0]  count_q;

	enc_t                enc;
	load_t               load;
	logic [STREAM_W-1:0] stream;
	logic [STREAM_W-1:0] rest;
	logic [LEN_W-1:0]    tot;
	logic                q_free;
	logic                adv;
	logic                push;
	logic [7:0]          partial_d;
	logic [2:0]          count_d;

	pvbp_field_enc u_enc (
		.func  (func_s1),
		.value (value_s1),
		.nbits (nbits_s1),
		.limit (limit_s1),
		.enc   (enc)
	);

	// splice the new bits in behind the partial byte
	assign stream = {partial_q, {ENC_W{1'b0}}} | ({enc.bits, 8'd0} >> count_q);
	assign tot    = {3'd0, count_q} + enc.len;
	assign rest   = stream << {tot[5:3], 3'b000};

	always_comb begin
		if (enc.align) begin
			// flush: pad the partial byte, or report an empty end marker
			load.bytes  = {partial_q, 32'd0};
			load.nbytes = 3'd1;
			load.bv     = (count_q != 3'd0);
			load.eom    = 1'b1;
			partial_d   = 8'd0;
			count_d     = 3'd0;
		end else begin
			load.bytes  = stream[STREAM_W-1 -: ENC_W];
			load.nbytes = tot[5:3];
			load.bv     = 1'b1;
			load.eom    = 1'b0;
			partial_d   = rest[STREAM_W-1 -: 8];
			count_d     = tot[2:0];
		end
	end

	// an operation that makes no byte needs no queue space
	assign adv      = valid_s1 && ((load.nbytes == 3'd0) || q_free);
	assign push     = adv && (load.nbytes != 3'd0);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			partial_q <= 8'd0;
			count_q   <= 3'd0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv) begin
				partial_q <= partial_d;
				count_q   <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1  <= func;
			value_s1 <= value;
			nbits_s1 <= nbits;
			limit_s1 <= limit;
		end
	end

	pvbp_byte_queue u_queue (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.load           (load),
		.free           (q_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message)
	);

endmodule

// File: rtl/pvbp_checker.sv
// ----------------------------------------------------------------------------
// pvbp_checker
// Port-level checks on the bit packer's channels, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  func,
	input logic [31:0] value,
	input logic [5:0]  nbits,
	input logic [31:0] limit,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        end_of_message
);

	// an empty result only comes from align
	`PVBP_ASSERT_IMPL(a_empty_is_eom, out_valid && !byte_valid, end_of_message)
	// an empty result carries a zero byte
	`PVBP_ASSERT_IMPL(a_empty_zero, out_valid && !byte_valid, out_byte == 8'd0)
	// a stalled result holds
	`PVBP_ASSERT_HOLD(a_out_hold, out_valid, out_ready, {out_byte, byte_valid, end_of_message})
	// a waiting operation holds
	`PVBP_ASSERT_HOLD(a_in_hold, in_valid, in_ready, {func, value, nbits, limit})

endmodule

bind prefix_varint_bit_packer_top pvbp_checker u_pvbp_checker (.*);

// File: tb/sv/tb_prefix_varint_bit_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_varint_bit_packer_top
// Self-checking bench for the prefix varint bit packer. It sends operations
// through the valid/ready input channel, keeps its own bit-level model of the
// packed stream, and checks every output transaction in order against it.
// Both channels idle at random, with some stretches that run flat out.
// ----------------------------------------------------------------------------
module tb_prefix_varint_bit_packer_top;
	import pvbp_pkg::*;

	// codes above align are not operations; the block drops them
	localparam logic [2:0] FUNC_SPARE_LO = FUNC_ALIGN + 3'd1;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	localparam int MAX_IDLE     = 12;   // longest gap or stall per transaction
	localparam int DRAIN_CYCLES = 20;   // settle time once the stream is empty
	localparam int STALL_LIMIT  = 1000; // cycles with no transaction at all

	// one byte of the packed stream as the output channel presents it
	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       eom;
	} stream_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  func = '0;
	logic [31:0] value = '0;
	logic [5:0]  nbits = '0;
	logic [31:0] limit = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        end_of_message;

	// predicted stream bytes still to arrive, oldest first
	stream_byte_t pending_bytes[$];
	// the model's partial byte: written bits sit at the top
	logic [7:0]   acc_byte = '0;
	int           acc_count = 0;

	int  mismatch_count = 0;
	int  idle_cycles = 0;
	bit  tx_gaps_on = 1'b1;
	bit  rx_stalls_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	prefix_varint_bit_packer_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.value          (value),
		.nbits          (nbits),
		.limit          (limit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message)
	);

	// ------------------------------------------------------------------
	// Stream model
	// ------------------------------------------------------------------

	function automatic void push_stream_byte(logic [7:0] data, logic vld, logic eom);
		stream_byte_t b;
		b.data  = data;
		b.valid = vld;
		b.eom   = eom;
		pending_bytes.push_back(b);
	endfunction

	// Low n bits of v, MSB first; each completed byte goes out at once.
	function automatic void stream_bits(logic [31:0] v, int n);
		for (int i = n; i > 0; i--) begin
			if (v[i-1])
				acc_byte = acc_byte | (8'h80 >> acc_count);
			acc_count++;
			if (acc_count == 8) begin
				push_stream_byte(acc_byte, 1'b1, 1'b0);
				acc_byte  = '0;
				acc_count = 0;
			end
		end
	endfunction

	// Raw field: whole bytes low byte first, then the low bits of the next.
	function automatic void stream_raw(logic [31:0] v, int n);
		int idx;
		idx = 0;
		if (n > 32)
			n = 32;
		while (n >= 8) begin
			stream_bits((v >> (8 * idx)) & 32'hff, 8);
			n -= 8;
			idx++;
		end
		if (n != 0)
			stream_bits((v >> (8 * idx)) & ((32'h1 << n) - 32'h1), n);
	endfunction

	function automatic int bit_length(logic [31:0] v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v = v >> 1;
		end
		return n;
	endfunction

	// Stream bytes caused by one accepted operation.
	function automatic void predict_packing(logic [2:0] f, logic [31:0] v,
			logic [5:0] nb, logic [31:0] lim);
		logic        neg;
		logic [31:0] mag;
		neg = v[31];
		mag = neg ? (32'h0 - v) : v;
		case (f)
			FUNC_UVAR: begin
				if (v <= U1_MAX)
					stream_bits(32'h80 | v, 8);
				else if (v <= U2_MAX)
					stream_bits(32'h4000 | v, 16);
				else if (v <= U4_MAX)
					stream_bits(32'h2000_0000 | v, 32);
				else begin
					stream_bits(32'h0, 3);
					stream_raw(v, 32);
				end
			end
			FUNC_SVAR: begin
				if (mag <= S1_MAX)
					stream_bits(32'h80 | (neg ? 32'h40 : 32'h0) | mag, 8);
				else if (mag <= S2_MAX)
					stream_bits(32'h4000 | (neg ? 32'h2000 : 32'h0) | mag, 16);
				else if (mag <= S4_MAX)
					stream_bits(32'h2000_0000 | (neg ? 32'h1000_0000 : 32'h0) | mag, 32);
				else begin
					stream_bits(32'h0, 3);
					stream_raw(v, 32);
				end
			end
			FUNC_RAW:
				stream_raw(v, int'(nb));
			FUNC_LIMIT:
				if (lim != 0)
					stream_raw(v, bit_length(lim));
			FUNC_ALIGN: begin
				if (acc_count != 0) begin
					push_stream_byte(acc_byte, 1'b1, 1'b1);
					acc_byte  = '0;
					acc_count = 0;
				end else begin
					push_stream_byte(8'h00, 1'b0, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// One operation per call. Valid is left high on return so a back-to-back
	// transaction never lowers and raises it in the same step.
	task automatic send_op(input logic [2:0] f, input logic [31:0] v,
			input logic [5:0] nb, input logic [31:0] lim);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			func     <= 3'($urandom);
			value    <= $urandom;
			nbits    <= 6'($urandom);
			limit    <= $urandom;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		nbits    <= nb;
		limit    <= lim;
		do @(posedge clk); while (!in_ready);
		predict_packing(f, v, nb, lim);
	endtask

	// Hold the sender off until every predicted byte has been taken.
	task automatic wait_stream_drained();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Value of random bit length, so every varint class gets hit.
	function automatic logic [31:0] rand_sized_value();
		int w;
		w = $urandom_range(0, 32);
		if (w == 32)
			return $urandom;
		return $urandom & ((32'h1 << w) - 32'h1);
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stalls, then ready held until a transaction
	// ------------------------------------------------------------------

	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = rx_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Each output transaction against the oldest prediction.
	always @(posedge clk) begin
		stream_byte_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte: actual data=%02h valid=%0b eom=%0b",
					$time, out_byte, byte_valid, end_of_message);
				mismatch_count++;
			end else begin
				exp_b = pending_bytes.pop_front();
				if (out_byte !== exp_b.data) begin
					$display("%0t: out_byte expected %02h actual %02h",
						$time, exp_b.data, out_byte);
					mismatch_count++;
				end
				if (byte_valid !== exp_b.valid) begin
					$display("%0t: byte_valid expected %0b actual %0b",
						$time, exp_b.valid, byte_valid);
					mismatch_count++;
				end
				if (end_of_message !== exp_b.eom) begin
					$display("%0t: end_of_message expected %0b actual %0b",
						$time, exp_b.eom, end_of_message);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long without a transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// one- and two-byte classes, plus the 000 fallback
	task automatic test_unsigned_varint();
		send_op(FUNC_UVAR, 32'h0000_0000, '0, '0);
		send_op(FUNC_UVAR, 32'h0000_0080, '0, '0);
		send_op(FUNC_UVAR, 32'h0000_3fff, '0, '0);
		send_op(FUNC_UVAR, 32'h2000_0000, '0, '0);
		send_op(FUNC_UVAR, 32'hffff_ffff, '0, '0);
	endtask

	// both signs, class edges, and the most negative value
	task automatic test_signed_varint();
		send_op(FUNC_SVAR, 32'hffff_ffc1, '0, '0);
		send_op(FUNC_SVAR, 32'h0000_0040, '0, '0);
		send_op(FUNC_SVAR, 32'hffff_e001, '0, '0);
		send_op(FUNC_SVAR, 32'h0fff_ffff, '0, '0);
		send_op(FUNC_SVAR, 32'h8000_0000, '0, '0);
	endtask

	// zero width, odd width, full width, width clamped to 32
	task automatic test_raw_field();
		send_op(FUNC_RAW, 32'hffff_ffff, 6'd0, '0);
		send_op(FUNC_RAW, 32'h0000_0015, 6'd5, '0);
		send_op(FUNC_RAW, 32'hffff_ffff, 6'd32, '0);
		send_op(FUNC_RAW, 32'h1234_5678, 6'd63, '1);
	endtask

	// limit zero writes nothing; one bit; full 32 bits
	task automatic test_limited_field();
		send_op(FUNC_LIMIT, 32'hffff_ffff, '1, 32'h0000_0000);
		send_op(FUNC_LIMIT, 32'h0000_0001, '0, 32'h0000_0001);
		send_op(FUNC_LIMIT, 32'ha5c3_0ff0, '0, 32'hffff_ffff);
	endtask

	// align with bits pending, then align on an empty partial byte
	task automatic test_align_and_end();
		send_op(FUNC_RAW, 32'h0000_0007, 6'd3, '0);
		send_op(FUNC_ALIGN, 32'hffff_ffff, '1, '1);
		send_op(FUNC_ALIGN, '0, '0, '0);
	endtask

	// spare codes must leave the partial byte alone
	task automatic test_unknown_func();
		send_op(FUNC_RAW, 32'h0000_0001, 6'd1, '0);
		send_op(FUNC_SPARE_HI, '1, '1, '1);
		send_op(FUNC_SPARE_LO, '1, '1, '1);
		send_op(FUNC_ALIGN, '0, '0, '0);
	endtask

	task automatic test_random_stream(input int count);
		int          pick;
		logic [2:0]  f;
		logic [31:0] v;
		logic [5:0]  nb;
		logic [31:0] lim;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 22)      f = FUNC_UVAR;
			else if (pick < 44) f = FUNC_SVAR;
			else if (pick < 66) f = FUNC_RAW;
			else if (pick < 84) f = FUNC_LIMIT;
			else if (pick < 94) f = FUNC_ALIGN;
			else                f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
			v = rand_sized_value();
			if (f == FUNC_SVAR && $urandom_range(0, 1))
				v = 32'h0 - v;
			nb  = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, 33))
				: 6'($urandom_range(34, 63));
			lim = ($urandom_range(0, 9) != 0) ? rand_sized_value() : 32'h0;
			send_op(f, v, nb, lim);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unsigned_varint();
		test_signed_varint();
		test_raw_field();
		test_limited_field();
		test_align_and_end();
		test_unknown_func();

		test_random_stream(70);
		// let the output side empty completely before carrying on
		wait_stream_drained();
		test_random_stream(30);

		// flat out on both sides
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		test_random_stream(50);

		// receiver stalls against a sender that never waits
		rx_stalls_on = 1'b1;
		test_random_stream(30);

		tx_gaps_on = 1'b1;
		test_random_stream(40);

		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pvbp_pkg.sv
rtl/pvbp_field_enc.sv
rtl/pvbp_byte_queue.sv
rtl/prefix_varint_bit_packer_top.sv
rtl/pvbp_checker.sv
tb/sv/tb_prefix_varint_bit_packer_top.sv
